FILE: src/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

	// screen geometry and name buffer size
	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int NAME_MAX = 14;

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);

	// longest colour name is thirteen characters
	localparam int NAME_CHARS = 13;
	localparam int NAME_BITS  = 8 * NAME_CHARS;

	// item kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// special characters
	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NONE    = 8'h00;

	localparam logic [3:0]  COLOR_DEFAULT = 4'd7;
	localparam logic [15:0] BLANK_CELL    = {4'h0, COLOR_DEFAULT, CH_SPACE};

	typedef enum logic [1:0] {
		SCR_NONE,
		SCR_WRITE,
		SCR_READ,
		SCR_SCROLL
	} scr_op_t;

	typedef struct packed {
		scr_op_t             op;
		logic [ADDR_W-1:0]   addr;
		logic [15:0]         wdata;
	} scr_req_t;

	typedef struct packed {
		logic        busy;
		logic [15:0] rdata;
	} scr_stat_t;

	typedef enum logic [1:0] {
		SW_CLEAR,
		SW_IDLE,
		SW_COPY,
		SW_BLANK
	} sweep_state_t;

	typedef enum logic [2:0] {
		ENG_IDLE,
		ENG_READ,
		ENG_SCROLL_GO,
		ENG_SCROLL_WAIT,
		ENG_DONE
	} eng_state_t;

	typedef struct packed {
		logic       emit;
		logic [3:0] color_next;
		logic [3:0] color;
	} esc_out_t;

	function automatic logic [3:0] name_len(input logic [3:0] k);
		logic [3:0] len;
		case (k)
			4'd0:    len = 4'd5;
			4'd1:    len = 4'd4;
			4'd2:    len = 4'd5;
			4'd3:    len = 4'd4;
			4'd4:    len = 4'd3;
			4'd5:    len = 4'd7;
			4'd6:    len = 4'd5;
			4'd7:    len = 4'd10;
			4'd8:    len = 4'd9;
			4'd9:    len = 4'd10;
			4'd10:   len = 4'd11;
			4'd11:   len = 4'd10;
			4'd12:   len = 4'd9;
			4'd13:   len = 4'd13;
			4'd14:   len = 4'd11;
			default: len = 4'd5;
		endcase
		return len;
	endfunction

	// names right-aligned, last character in the lowest byte
	function automatic logic [NAME_BITS-1:0] name_str(input logic [3:0] k);
		logic [NAME_BITS-1:0] s;
		case (k)
			4'd0:    s = NAME_BITS'("BLACK");
			4'd1:    s = NAME_BITS'("BLUE");
			4'd2:    s = NAME_BITS'("GREEN");
			4'd3:    s = NAME_BITS'("CYAN");
			4'd4:    s = NAME_BITS'("RED");
			4'd5:    s = NAME_BITS'("MAGENTA");
			4'd6:    s = NAME_BITS'("BROWN");
			4'd7:    s = NAME_BITS'({"LIGHT", "_GREY"});
			4'd8:    s = NAME_BITS'({"DARK", "_GREY"});
			4'd9:    s = NAME_BITS'({"LIGHT", "_BLUE"});
			4'd10:   s = NAME_BITS'({"LIGHT", "_GREEN"});
			4'd11:   s = NAME_BITS'({"LIGHT", "_CYAN"});
			4'd12:   s = NAME_BITS'({"LIGHT", "_RED"});
			4'd13:   s = NAME_BITS'({"LIGHT", "_MAGENTA"});
			4'd14:   s = NAME_BITS'({"LIGHT", "_BROWN"});
			default: s = NAME_BITS'("WHITE");
		endcase
		return s;
	endfunction

	// character i of colour name k, zero past its end
	function automatic logic [7:0] name_char(input logic [3:0] k, input logic [3:0] i);
		logic [3:0]           len;
		logic [NAME_BITS-1:0] s;
		logic [7:0]           c;
		len = name_len(k);
		s   = name_str(k);
		c   = CH_NONE;
		if (i < len) begin
			c = s[(int'(len) - 1 - int'(i)) * 8 +: 8];
		end
		return c;
	endfunction

endpackage

FILE: src/tcw_esc.sv
`timescale 1ns / 1ps

module tcw_esc (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             commit,
	input  logic [7:0]       char_code,
	input  logic             string_start,
	output tcw_pkg::esc_out_t esc
);
	import tcw_pkg::*;

	logic [3:0]  color_q, color_d, color0;
	logic        esc_q, esc_d, esc0;
	logic        lit_q, lit_d, lit0;
	logic [3:0]  len_q, len_d, len0;
	logic [15:0] mask_q, mask_d;
	logic        emit;
	logic        found;
	logic [3:0]  match_idx;

	always_comb begin
		color0 = string_start ? COLOR_DEFAULT : color_q;
		esc0   = string_start ? 1'b0 : esc_q;
		lit0   = string_start ? 1'b0 : lit_q;
		len0   = string_start ? 4'd0 : len_q;

		// candidate names are narrowed one character at a time
		found     = 1'b0;
		match_idx = color0;
		for (int k = 0; k < 16; k++) begin
			if (!found && mask_q[k] && name_len(4'(k)) == len0 && int'(len0) <= NAME_MAX) begin
				found     = 1'b1;
				match_idx = 4'(k);
			end
		end

		color_d = color0;
		esc_d   = esc0;
		lit_d   = lit0;
		len_d   = len0;
		mask_d  = mask_q;
		emit    = 1'b0;

		if (char_code != CH_NONE) begin
			if (lit0) begin
				lit_d = 1'b0;
				emit  = 1'b1;
			end else if (esc0) begin
				if (char_code == CH_BANG) begin
					color_d = match_idx;
					esc_d   = 1'b0;
					lit_d   = 1'b1;
				end else begin
					for (int k = 0; k < 16; k++) begin
						mask_d[k] = mask_q[k] &
							(int'(len0) >= NAME_MAX || name_char(4'(k), len0) == char_code);
					end
					if (len0 != 4'd15) begin
						len_d = len0 + 4'd1;
					end
				end
			end else if (char_code == CH_DOLLAR) begin
				esc_d  = 1'b1;
				len_d  = 4'd0;
				mask_d = '1;
			end else begin
				emit = 1'b1;
			end
		end

		esc.emit       = emit;
		esc.color_next = color_d;
		esc.color      = color_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= COLOR_DEFAULT;
			esc_q   <= 1'b0;
			lit_q   <= 1'b0;
			len_q   <= 4'd0;
			mask_q  <= '1;
		end else if (commit) begin
			color_q <= color_d;
			esc_q   <= esc_d;
			lit_q   <= lit_d;
			len_q   <= len_d;
			mask_q  <= mask_d;
		end
	end

endmodule

FILE: src/tcw_screen.sv
`timescale 1ns / 1ps

module tcw_screen (
	input  logic               clk,
	input  logic               arst_n,
	input  tcw_pkg::scr_req_t  req,
	output tcw_pkg::scr_stat_t stat
);
	import tcw_pkg::*;

	localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELLS - COLUMNS);

	logic [15:0] screen_mem [CELLS];

	sweep_state_t      sw_q, sw_d;
	logic [ADDR_W-1:0] ptr_q, ptr_d;
	logic              copy_s1, copy_d;
	logic [ADDR_W-1:0] copy_addr_s1;
	logic [15:0]       rdata_q;

	logic              we, re;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [15:0]       wdata;

	always_comb begin
		sw_d   = sw_q;
		ptr_d  = ptr_q;
		copy_d = 1'b0;
		we     = 1'b0;
		re     = 1'b0;
		waddr  = req.addr;
		raddr  = req.addr;
		wdata  = req.wdata;

		case (sw_q)
			SW_CLEAR: begin
				we    = 1'b1;
				waddr = ptr_q;
				wdata = BLANK_CELL;
				if (ptr_q == LAST_ADDR) begin
					sw_d  = SW_IDLE;
					ptr_d = '0;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			SW_IDLE: begin
				case (req.op)
					SCR_WRITE: we = 1'b1;
					SCR_READ:  re = 1'b1;
					SCR_SCROLL: begin
						sw_d  = SW_COPY;
						ptr_d = ROW_STRIDE;
					end
					default: ;
				endcase
			end
			SW_COPY: begin
				// read one row below, written back in the following cycle
				re     = 1'b1;
				raddr  = ptr_q;
				copy_d = 1'b1;
				if (ptr_q == LAST_ADDR) begin
					sw_d  = SW_BLANK;
					ptr_d = BOTTOM_ROW;
				end else begin
					ptr_d = ptr_q + 1'b1;
				end
			end
			SW_BLANK: begin
				if (!copy_s1) begin
					we    = 1'b1;
					waddr = ptr_q;
					wdata = BLANK_CELL;
					if (ptr_q == LAST_ADDR) begin
						sw_d  = SW_IDLE;
						ptr_d = '0;
					end else begin
						ptr_d = ptr_q + 1'b1;
					end
				end
			end
			default: sw_d = SW_IDLE;
		endcase

		if (copy_s1) begin
			we    = 1'b1;
			waddr = copy_addr_s1;
			wdata = rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q    <= SW_CLEAR;
			ptr_q   <= '0;
			copy_s1 <= 1'b0;
		end else begin
			sw_q    <= sw_d;
			ptr_q   <= ptr_d;
			copy_s1 <= copy_d;
		end
	end

	always_ff @(posedge clk) begin
		copy_addr_s1 <= ptr_q - ROW_STRIDE;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			screen_mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= screen_mem[raddr];
		end
	end

	assign stat.busy  = (sw_q != SW_IDLE);
	assign stat.rdata = rdata_q;

endmodule

FILE: src/text_console_writer.sv
`timescale 1ns / 1ps
// character item: accepted only while the engine is idle; its result passes from the done state
// into the output register. read item: the registered screen memory read adds the read state
// a new item waits until the last result is in the output register; an item that runs off the
// bottom row scrolls: the copy sweep through the screen memory, one cell a cycle, then the blank row
// reset: control state clears at once, then a clearing pass writes the blank cell into all
// ROWS*COLUMNS entries while item_stall stays high

module text_console_writer (
	input  logic        clk,
	input  logic        arst_n,

	// item channel
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        kind,
	input  logic [7:0]  char_code,
	input  logic        string_start,
	input  logic [4:0]  read_row,
	input  logic [6:0]  read_col,

	// result channel
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] cell_value,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_col,
	output logic [3:0]  text_color
);
	import tcw_pkg::*;

	localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
	localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);

	eng_state_t        state_q, state_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [ADDR_W-1:0] base_q, base_d;     // row_q * COLUMNS, kept alongside the cursor
	logic [15:0]       res_cell_q, res_cell_d;
	logic              rd_ok_q, rd_ok_d;

	logic              out_valid_q;
	logic [15:0]       out_cell_q;
	logic [4:0]        out_row_q;
	logic [6:0]        out_col_q;
	logic [3:0]        out_color_q;

	logic              accept;
	logic              commit;
	logic              out_load;
	logic              wrap;
	logic              rd_in_range;
	logic [ADDR_W-1:0] rd_addr;
	logic [15:0]       new_cell;

	esc_out_t  esc;
	scr_req_t  req;
	scr_stat_t stat;

	// escape sequence and colour name tracking
	tcw_esc u_esc (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (commit),
		.char_code    (char_code),
		.string_start (string_start),
		.esc          (esc)
	);

	// screen memory with clearing and scroll sweeps
	tcw_screen u_screen (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.stat   (stat)
	);

	// a new item only when the engine is idle and no sweep is running
	assign item_stall = !(state_q == ENG_IDLE && !stat.busy);
	assign accept     = item_valid && !item_stall;

	assign rd_in_range = (int'(read_row) < ROWS) && (int'(read_col) < COLUMNS);
	assign rd_addr     = ADDR_W'(ADDR_W'(read_row) * ROW_STRIDE) + ADDR_W'(read_col);
	assign new_cell    = {4'h0, esc.color_next, char_code};

	always_comb begin
		state_d    = state_q;
		row_d      = row_q;
		col_d      = col_q;
		base_d     = base_q;
		res_cell_d = res_cell_q;
		rd_ok_d    = rd_ok_q;
		commit     = 1'b0;
		out_load   = 1'b0;
		wrap       = 1'b0;
		req.op     = SCR_NONE;
		req.addr   = base_q + ADDR_W'(col_q);
		req.wdata  = new_cell;

		case (state_q)
			ENG_IDLE: begin
				if (accept) begin
					if (kind == KIND_READ) begin
						// out-of-range cells read as zero, no memory access
						rd_ok_d  = rd_in_range;
						req.op   = rd_in_range ? SCR_READ : SCR_NONE;
						req.addr = rd_addr;
						state_d  = ENG_READ;
					end else begin
						commit     = 1'b1;
						res_cell_d = '0;
						state_d    = ENG_DONE;
						if (esc.emit) begin
							if (char_code == CH_NL) begin
								wrap = 1'b1;
							end else begin
								req.op     = SCR_WRITE;
								res_cell_d = new_cell;
								if (col_q == LAST_COL) begin
									wrap = 1'b1;
								end else begin
									col_d = col_q + 1'b1;
								end
							end
						end
						if (wrap) begin
							col_d = '0;
							if (row_q == LAST_ROW) begin
								// cursor stays on the bottom row, screen moves up
								state_d = ENG_SCROLL_GO;
							end else begin
								row_d  = row_q + 1'b1;
								base_d = base_q + ROW_STRIDE;
							end
						end
					end
				end
			end
			ENG_READ: begin
				res_cell_d = rd_ok_q ? stat.rdata : 16'h0000;
				state_d    = ENG_DONE;
			end
			ENG_SCROLL_GO: begin
				req.op  = SCR_SCROLL;
				state_d = ENG_SCROLL_WAIT;
			end
			ENG_SCROLL_WAIT: begin
				if (!stat.busy) begin
					state_d = ENG_DONE;
				end
			end
			ENG_DONE: begin
				// hand the result over once the output register is free
				if (!out_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_d  = ENG_IDLE;
				end
			end
			default: state_d = ENG_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ENG_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			base_q      <= '0;
			rd_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
			base_q  <= base_d;
			rd_ok_q <= rd_ok_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		res_cell_q <= res_cell_d;
		if (out_load) begin
			out_cell_q  <= res_cell_q;
			out_row_q   <= 5'(row_q);
			out_col_q   <= 7'(col_q);
			out_color_q <= esc.color;
		end
	end

	assign result_valid = out_valid_q;
	assign cell_value   = out_cell_q;
	assign cursor_row   = out_row_q;
	assign cursor_col   = out_col_q;
	assign text_color   = out_color_q;

endmodule

FILE: src/tcw_checker.sv
`timescale 1ns / 1ps

module tcw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        kind,
	input logic [7:0]  char_code,
	input logic        string_start,
	input logic [4:0]  read_row,
	input logic [6:0]  read_col,
	input logic        result_valid,
	input logic        result_stall,
	input logic [15:0] cell_value,
	input logic [4:0]  cursor_row,
	input logic [6:0]  cursor_col,
	input logic [3:0]  text_color
);
	import tcw_pkg::*;

	// an accepted item holds the engine, so no two items are accepted back to back
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item accepted on two consecutive cycles");

	// a stalled input item holds
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(kind) && $stable(char_code) &&
			$stable(string_start) && $stable(read_row) && $stable(read_col))
		else $error("stalled item changed");

	// the cursor never leaves the screen
	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (int'(cursor_col) < COLUMNS) && (int'(cursor_row) < ROWS))
		else $error("cursor off screen");

	// background is always black
	a_black_background: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> cell_value[15:12] == 4'h0)
		else $error("cell with non-black background");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(cell_value) &&
			$stable(cursor_row) && $stable(cursor_col) && $stable(text_color))
		else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import tcw_pkg::*;

	// run shape
	localparam int ITEM_TARGET = 1900;   // directed plus random items queued
	localparam int CALM_TAIL   = 150;    // last items run with no idling on either side
	localparam int HOLD_AFTER  = 300;    // results seen before the long receiver hold
	localparam int LONG_HOLD   = 400;    // cycles of that hold
	localparam int END_DRAIN   = 2100;   // longer than one scroll sweep
	// room for the worst case: every item scrolls and meets both the longest send gap and result stall
	localparam longint RUN_LIMIT_NS = 64'd150_000_000;

	// one input item and the result it should cause
	typedef struct {
		logic       kind;
		logic [7:0] code;
		logic       start;
		logic [4:0] row;
		logic [6:0] col;
	} console_item_t;

	typedef struct {
		logic [15:0] cell_val;
		logic [4:0]  row;
		logic [6:0]  col;
		logic [3:0]  colour;
	} console_view_t;

	logic        clk;
	logic        arst_n = 1'b0;

	// every block input starts at a known value
	logic        item_valid   = 1'b0;
	logic        kind         = KIND_CHAR;
	logic [7:0]  char_code    = CH_NONE;
	logic        string_start = 1'b0;
	logic [4:0]  read_row     = '0;
	logic [6:0]  read_col     = '0;
	logic        result_stall = 1'b0;

	logic        item_stall;
	logic        result_valid;
	logic [15:0] cell_value;
	logic [4:0]  cursor_row;
	logic [6:0]  cursor_col;
	logic [3:0]  text_color;

	text_console_writer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.kind         (kind),
		.char_code    (char_code),
		.string_start (string_start),
		.read_row     (read_row),
		.read_col     (read_col),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cell_value   (cell_value),
		.cursor_row   (cursor_row),
		.cursor_col   (cursor_col),
		.text_color   (text_color)
	);

	// items waiting to be offered, and results still owed by the block
	console_item_t pending_items[$];
	console_view_t expected_views[$];

	int mismatches   = 0;
	int results_seen = 0;

	// ---------------------------------------------------------------
	// console shadow: screen, cursor, colour and the escape parser
	// ---------------------------------------------------------------

	string colour_names [16] = '{
		"BLACK", "BLUE", "GREEN", "CYAN", "RED", "MAGENTA", "BROWN",
		{"LIGHT", "_GREY"}, {"DARK", "_GREY"}, {"LIGHT", "_BLUE"}, {"LIGHT", "_GREEN"},
		{"LIGHT", "_CYAN"}, {"LIGHT", "_RED"}, {"LIGHT", "_MAGENTA"}, {"LIGHT", "_BROWN"},
		"WHITE"
	};

	logic [15:0] screen_shadow [CELLS];
	int          shadow_row;
	int          shadow_col;
	logic [3:0]  shadow_colour;
	bit          in_escape;
	bit          literal_pending;
	logic [7:0]  name_shadow [NAME_MAX];
	int          name_count;

	// cursor to column 0 of the next row; off the bottom the screen moves up a row
	function automatic void advance_row();
		shadow_col = 0;
		if (shadow_row + 1 >= ROWS) begin
			for (int i = 0; i < CELLS - COLUMNS; i++)
				screen_shadow[i] = screen_shadow[i + COLUMNS];
			for (int i = CELLS - COLUMNS; i < CELLS; i++)
				screen_shadow[i] = BLANK_CELL;
			shadow_row = ROWS - 1;
		end else begin
			shadow_row++;
		end
	endfunction

	// print one character at the cursor; a newline writes nothing
	function automatic logic [15:0] print_char(input logic [7:0] ch);
		logic [15:0] written;
		if (ch == CH_NL) begin
			advance_row();
			return 16'h0000;
		end
		written = {4'h0, shadow_colour, ch};
		screen_shadow[shadow_row * COLUMNS + shadow_col] = written;
		shadow_col++;
		if (shadow_col >= COLUMNS)
			advance_row();
		return written;
	endfunction

	// exact match of the collected name; too long or unknown leaves the colour alone
	function automatic void apply_colour_name();
		bit same;
		if (name_count > NAME_MAX)
			return;
		for (int k = 0; k < 16; k++) begin
			if (colour_names[k].len() == name_count) begin
				same = 1'b1;
				for (int i = 0; i < name_count; i++)
					if (colour_names[k][i] != name_shadow[i])
						same = 1'b0;
				if (same) begin
					shadow_colour = 4'(k);
					return;
				end
			end
		end
	endfunction

	function automatic console_view_t console_step(input console_item_t it);
		console_view_t view;
		logic [15:0]   cell_val;
		cell_val = 16'h0000;
		if (it.kind == KIND_READ) begin
			if (it.row < ROWS && it.col < COLUMNS)
				cell_val = screen_shadow[it.row * COLUMNS + it.col];
		end else begin
			// string start wins over whatever the parser was doing
			if (it.start) begin
				shadow_colour   = COLOR_DEFAULT;
				in_escape       = 1'b0;
				literal_pending = 1'b0;
				name_count      = 0;
			end
			if (it.code != CH_NONE) begin
				if (literal_pending) begin
					literal_pending = 1'b0;
					cell_val = print_char(it.code);
				end else if (in_escape) begin
					if (it.code == CH_BANG) begin
						apply_colour_name();
						in_escape       = 1'b0;
						literal_pending = 1'b1;
					end else begin
						if (name_count < NAME_MAX)
							name_shadow[name_count] = it.code;
						if (name_count < 15)
							name_count++;
					end
				end else if (it.code == CH_DOLLAR) begin
					in_escape  = 1'b1;
					name_count = 0;
				end else begin
					cell_val = print_char(it.code);
				end
			end
		end
		view.cell_val = cell_val;
		view.row      = 5'(shadow_row);
		view.col      = 7'(shadow_col);
		view.colour   = shadow_colour;
		return view;
	endfunction

	// ---------------------------------------------------------------
	// stimulus builders
	// ---------------------------------------------------------------

	// read position fields are don't-care here but still toggled
	task automatic push_char(input logic [7:0] code, input logic start);
		console_item_t it;
		it.kind  = KIND_CHAR;
		it.code  = code;
		it.start = start;
		it.row   = 5'($urandom);
		it.col   = 7'($urandom);
		pending_items.push_back(it);
	endtask

	task automatic push_read(input logic [4:0] row, input logic [6:0] col);
		console_item_t it;
		it.kind  = KIND_READ;
		it.code  = 8'($urandom);
		it.start = 1'($urandom);
		it.row   = row;
		it.col   = col;
		pending_items.push_back(it);
	endtask

	task automatic push_name(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], 1'b0);
	endtask

	// ---------------------------------------------------------------
	// clock, reset, stimulus and end of run
	// ---------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin : run_control
		string      word;
		int         pick;
		int         run_len;
		int         variant;
		logic [7:0] code;

		// shadow matches the block after reset
		for (int i = 0; i < CELLS; i++)
			screen_shadow[i] = BLANK_CELL;
		shadow_row      = 0;
		shadow_col      = 0;
		shadow_colour   = COLOR_DEFAULT;
		in_escape       = 1'b0;
		literal_pending = 1'b0;
		name_count      = 0;

		// directed: corner reads, zero byte, a colour change, escape oddities
		push_read(5'd0, 7'd0);
		push_read(5'h1F, 7'h7F);                    // far out of range, all bits set
		push_read(5'(ROWS - 1), 7'(COLUMNS - 1));
		push_char(8'hFF, 1'b1);
		push_char(CH_NONE, 1'b0);                   // zero byte does nothing
		push_char(CH_DOLLAR, 1'b0);
		push_name("RED");
		push_char(CH_BANG, 1'b0);
		push_char(CH_DOLLAR, 1'b0);                 // printed as is, in red
		push_char(CH_NL, 1'b0);
		push_char(CH_DOLLAR, 1'b0);
		push_char(CH_NL, 1'b0);                     // newline collected into the name
		push_char(CH_BANG, 1'b0);                   // unknown name, colour kept
		push_char(CH_NL, 1'b0);                     // literal newline still moves down
		push_char(CH_DOLLAR, 1'b0);
		push_name("BLUE");
		push_char(CH_NONE, 1'b1);                   // string start drops the half name
		push_char(8'h42, 1'b0);
		push_read(5'd0, 7'd0);
		push_read(5'd0, 7'(COLUMNS));               // first column past the edge
		push_read(5'(ROWS), 7'd0);                  // first row past the edge

		// random: mostly text and well formed colour escapes, then reads and noise
		while (pending_items.size() < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				// text run, now and then long enough to wrap a line
				run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(81, 170)
				                                        : $urandom_range(1, 30);
				for (int i = 0; i < run_len; i++) begin
					if ($urandom_range(0, 14) == 0) begin
						code = CH_NL;
					end else begin
						code = 8'($urandom_range(32, 126));
						if (code == CH_DOLLAR)
							code = CH_SPACE;
					end
					push_char(code, i == 0 && $urandom_range(0, 3) == 0);
				end
			end else if (pick < 60) begin
				// proper colour change followed by any literal byte
				push_char(CH_DOLLAR, $urandom_range(0, 5) == 0);
				push_name(colour_names[$urandom_range(0, 15)]);
				push_char(CH_BANG, 1'b0);
				push_char(8'($urandom), 1'b0);
			end else if (pick < 72) begin
				// damaged escapes
				push_char(CH_DOLLAR, 1'b0);
				word    = colour_names[$urandom_range(0, 15)];
				variant = $urandom_range(0, 5);
				case (variant)
					0: begin
						// lengthened by random letters, at times past the name buffer and the length counter
						repeat ($urandom_range(1, 8))
							word = {word, string'(8'($urandom_range(65, 90)))};
					end
					1: word[$urandom_range(0, word.len() - 1)] = 8'($urandom_range(1, 255));
					2: word = word.substr(0, word.len() - 2);
					3: word = {string'(CH_NL), word};
					default: ;
				endcase
				if (variant == 4) begin
					// string start in the middle of a name
					push_name(word.substr(0, $urandom_range(0, word.len() - 1)));
					push_char(8'($urandom_range(32, 126)), 1'b1);
				end else begin
					push_name(word);
					push_char(CH_BANG, 1'b0);
					// variant 5 cancels the pending literal with a string start
					push_char(8'($urandom_range(32, 126)), variant == 5);
				end
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 7) == 0)
						push_read(5'($urandom), 7'($urandom));
					else
						push_read(5'($urandom_range(0, ROWS - 1)),
						          7'($urandom_range(0, COLUMNS - 1)));
				end
			end else begin
				// raw bytes, zero and dollar included
				repeat ($urandom_range(1, 6))
					push_char(8'($urandom), $urandom_range(0, 3) == 0);
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// everything offered and taken, then every result back
		while (pending_items.size() != 0 || item_valid)
			@(posedge clk);
		while (expected_views.size() != 0)
			@(posedge clk);
		// catch stray results from a late scroll
		repeat (END_DRAIN) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("%0t: run limit reached, %0d results still owed", $time, expected_views.size());
		$display("Mismatches found");
		$finish;
	end

	// ---------------------------------------------------------------
	// item driver: takes the next pending item, with random gaps
	// ---------------------------------------------------------------

	int            send_gap = 0;
	console_item_t item_on_bus;

	always @(posedge clk or negedge arst_n) begin : drive_items
		if (!arst_n) begin
			item_valid <= 1'b0;
			send_gap = 0;
		end else begin
			// accepted at this edge: shadow steps and the result is owed
			if (item_valid && !item_stall)
				expected_views.push_back(console_step(item_on_bus));

			// a stalled item stays put
			if (!item_valid || !item_stall) begin
				if (send_gap != 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item_on_bus = pending_items.pop_front();
					kind         <= item_on_bus.kind;
					char_code    <= item_on_bus.code;
					string_start <= item_on_bus.start;
					read_row     <= item_on_bus.row;
					read_col     <= item_on_bus.col;
					item_valid   <= 1'b1;
					// gap after this item, none near the end
					if (pending_items.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
						send_gap = $urandom_range(1, 16);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// result monitor: checks against the oldest owed result, stalls at random
	// ---------------------------------------------------------------

	function automatic void check_field(input string what, input logic [15:0] want,
	                                    input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	int stall_left     = 0;
	bit long_hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin : watch_results
		console_view_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_views.size() == 0) begin
					$display("%0t: result expected none, got cell %0h row %0d col %0d colour %0d",
					         $time, cell_value, cursor_row, cursor_col, text_color);
					mismatches++;
				end else begin
					want = expected_views.pop_front();
					check_field("cell_value", want.cell_val, cell_value);
					check_field("cursor_row", 16'(want.row), 16'(cursor_row));
					check_field("cursor_col", 16'(want.col), 16'(cursor_col));
					check_field("text_color", 16'(want.colour), 16'(text_color));
				end
			end

			// one long hold so the block backs up into its input, else short bursts
			if (!long_hold_done && results_seen >= HOLD_AFTER) begin
				stall_left     = LONG_HOLD;
				long_hold_done = 1'b1;
			end else if (stall_left == 0 && pending_items.size() >= CALM_TAIL
			             && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(1, 16);
			end

			if (stall_left != 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

endmodule
